/* rtl/core/int_to_decimal_ascii_assert.svh */
// Assertion helpers for the decimal text converter.
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Condition that holds on every clock outside reset.
`define ITDA_ASSERT_HOLDS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("itda: invariant violated");

// Same-cycle implication outside reset.
`define ITDA_ASSERT_IMPL(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("itda: implication violated");

`endif

/* rtl/core/itda_pkg.sv */
`timescale 1ns / 1ps

package itda_pkg;

   // mode codes carried on tuser
   typedef enum logic [1:0] {
      CMD_S32 = 2'd0,
      CMD_S64 = 2'd1,
      CMD_U32 = 2'd2,
      CMD_U64 = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   localparam int MagW       = 64;
   localparam int NumDigits  = 20;
   localparam int BcdW       = NumDigits * 4;
   localparam int DigW       = 5;
   localparam int StepBits   = 8;
   localparam int WideSteps  = MagW / StepBits;
   localparam int NarrowSteps = (MagW / 2) / StepBits;
   localparam int CntW       = 3;

   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChMinus = 8'h2D;

   // Eight shift-add-3 steps: fold eight more binary bits into the BCD word.
   function automatic logic [BcdW-1:0] dabble_step(input logic [BcdW-1:0] bcd,
                                                   input logic [StepBits-1:0] bits);
      logic [BcdW-1:0] acc;
      acc = bcd;
      for (int s = 0; s < StepBits; s++) begin
         for (int d = 0; d < NumDigits; d++) begin
            if (acc[d*4 +: 4] >= 4'd5) begin
               acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
            end
         end
         acc = {acc[BcdW-2:0], bits[StepBits-1-s]};
      end
      return acc;
   endfunction

   function automatic logic bcd_valid(input logic [BcdW-1:0] bcd);
      logic ok;
      ok = 1'b1;
      for (int d = 0; d < NumDigits; d++) begin
         if (bcd[d*4 +: 4] > 4'd9) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

/* rtl/core/int_to_decimal_ascii.sv */
// Sequence: an accepted number is converted in ST_CONV by the 8-bit-per-cycle double-dabble unit,
//   ST_SKIP then drops the leading zero digits of the 20-digit BCD word, and the characters
//   follow at one character per cycle while rsp_tready is high. A new number is accepted only
//   in ST_IDLE, after the last character of the previous number has been issued.
// Reset: synchronous, active high; clears the sequencer and the output valid.
`timescale 1ns / 1ps

module int_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] value
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] ascii_char
   output logic        rsp_tlast    // last_char
);

`include "int_to_decimal_ascii_assert.svh"

   itda_pkg::state_type state_ff, state_in;
   logic [itda_pkg::BcdW-1:0] bcd_ff, bcd_in;
   logic [itda_pkg::MagW-1:0] bin_ff, bin_in;
   logic [itda_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic [itda_pkg::DigW-1:0] dig_ff, dig_in;
   logic                      neg_ff, neg_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic        is_signed;
   logic        wide;
   logic        negative;
   logic [31:0] mag32;
   logic [63:0] mag64;
   logic        out_free;
   logic [3:0]  top_digit;
   logic        bcd_ok;
   logic        sign_beat;

   always_comb begin
      is_signed = 1'b0;
      wide      = 1'b0;
      unique case (itda_pkg::cmd_type'(req_tuser))
         itda_pkg::CMD_S32: begin is_signed = 1'b1; wide = 1'b0; end
         itda_pkg::CMD_S64: begin is_signed = 1'b1; wide = 1'b1; end
         itda_pkg::CMD_U32: begin is_signed = 1'b0; wide = 1'b0; end
         itda_pkg::CMD_U64: begin is_signed = 1'b0; wide = 1'b1; end
         default:           begin is_signed = 1'b0; wide = 1'b0; end
      endcase
   end

   // unsigned negate: the most negative value maps to its own pattern, i.e. 2^31 / 2^63
   always_comb begin
      negative = is_signed && (wide ? req_tdata[63] : req_tdata[31]);
      mag32    = (is_signed && req_tdata[31]) ? (~req_tdata[31:0] + 32'd1) : req_tdata[31:0];
      mag64    = (is_signed && req_tdata[63]) ? (~req_tdata + 64'd1) : req_tdata;
   end

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign top_digit = bcd_ff[itda_pkg::BcdW-1 -: 4];
   assign bcd_ok    = itda_pkg::bcd_valid(bcd_ff);
   assign sign_beat = rsp_valid_ff && (rsp_data_ff == itda_pkg::ChMinus);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itda_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff      <= bcd_in;
      bin_ff      <= bin_in;
      cnt_ff      <= cnt_in;
      dig_ff      <= dig_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      bcd_in       = bcd_ff;
      bin_in       = bin_ff;
      cnt_in       = cnt_ff;
      dig_in       = dig_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;

      unique case (state_ff)
         itda_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               bcd_in   = '0;
               neg_in   = negative;
               bin_in   = wide ? mag64 : {mag32, 32'd0};
               cnt_in   = wide ? itda_pkg::CntW'(itda_pkg::WideSteps - 1)
                               : itda_pkg::CntW'(itda_pkg::NarrowSteps - 1);
               state_in = itda_pkg::ST_CONV;
            end
         end
         itda_pkg::ST_CONV: begin
            bcd_in = itda_pkg::dabble_step(bcd_ff,
                                           bin_ff[itda_pkg::MagW-1 -: itda_pkg::StepBits]);
            bin_in = bin_ff << itda_pkg::StepBits;
            cnt_in = cnt_ff - itda_pkg::CntW'(1);
            if (cnt_ff == '0) begin
               dig_in   = itda_pkg::DigW'(itda_pkg::NumDigits - 1);
               state_in = itda_pkg::ST_SKIP;
            end
         end
         itda_pkg::ST_SKIP: begin
            // drop leading zero digits, always keep the last one
            if (top_digit == 4'd0 && dig_ff != '0) begin
               bcd_in = bcd_ff << 4;
               dig_in = dig_ff - itda_pkg::DigW'(1);
            end else begin
               state_in = neg_ff ? itda_pkg::ST_SIGN : itda_pkg::ST_EMIT;
            end
         end
         itda_pkg::ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = itda_pkg::ChMinus;
               rsp_last_in  = 1'b0;
               state_in     = itda_pkg::ST_EMIT;
            end
         end
         itda_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = itda_pkg::ChZero + {4'd0, top_digit};
               rsp_last_in  = (dig_ff == '0);
               bcd_in       = bcd_ff << 4;
               dig_in       = dig_ff - itda_pkg::DigW'(1);
               if (dig_ff == '0) begin
                  state_in = itda_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = itda_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ITDA_ASSERT_IMPL(a_bcd_digits, clock, reset, (state_ff != itda_pkg::ST_IDLE), (bcd_ok))
   `ITDA_ASSERT_IMPL(a_sign_not_last, clock, reset, (sign_beat), (!rsp_last_ff))
   `ITDA_ASSERT_IMPL(a_sign_only_neg, clock, reset, (state_ff == itda_pkg::ST_SIGN), (neg_ff))
   `ITDA_ASSERT_HOLDS(a_ready_idle_only, clock, reset, (!req_tready || state_ff == itda_pkg::ST_IDLE))

endmodule
